FILE: sv/lsl_pkg.sv
package lsl_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_KEYWORD_LEN_DEF = 6;
    localparam int POSITION_BITS_DEF   = 32;

    // Fixed field widths
    localparam int KIND_W  = 6;
    localparam int FIELD_W = 32;
    localparam int LINE_W  = 32;

    // Tokens one source byte can cause, and groups the queue holds
    localparam int MAX_TOKENS  = 3;
    localparam int QUEUE_DEPTH = 4;

    // Keyword table
    localparam int KW_COUNT = 16;
    localparam int KW_CHARS = 6;

    // Scanner modes
    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_BANG,
        MODE_EQ,
        MODE_LESS,
        MODE_GREATER,
        MODE_SLASH,
        MODE_COMMENT,
        MODE_STRING,
        MODE_NUMBER,
        MODE_IDENT
    } mode_t;

    // Token kinds
    localparam logic [KIND_W-1:0] K_LPAREN     = 6'd0;
    localparam logic [KIND_W-1:0] K_RPAREN     = 6'd1;
    localparam logic [KIND_W-1:0] K_LBRACE     = 6'd2;
    localparam logic [KIND_W-1:0] K_RBRACE     = 6'd3;
    localparam logic [KIND_W-1:0] K_COMMA      = 6'd4;
    localparam logic [KIND_W-1:0] K_DOT        = 6'd5;
    localparam logic [KIND_W-1:0] K_MINUS      = 6'd6;
    localparam logic [KIND_W-1:0] K_PLUS       = 6'd7;
    localparam logic [KIND_W-1:0] K_SEMI       = 6'd8;
    localparam logic [KIND_W-1:0] K_STAR       = 6'd9;
    localparam logic [KIND_W-1:0] K_SLASH      = 6'd10;
    localparam logic [KIND_W-1:0] K_BANG       = 6'd11;
    localparam logic [KIND_W-1:0] K_BANG_EQ    = 6'd12;
    localparam logic [KIND_W-1:0] K_EQ         = 6'd13;
    localparam logic [KIND_W-1:0] K_EQ_EQ      = 6'd14;
    localparam logic [KIND_W-1:0] K_LESS       = 6'd15;
    localparam logic [KIND_W-1:0] K_LESS_EQ    = 6'd16;
    localparam logic [KIND_W-1:0] K_GREATER    = 6'd17;
    localparam logic [KIND_W-1:0] K_GREATER_EQ = 6'd18;
    localparam logic [KIND_W-1:0] K_STRING     = 6'd19;
    localparam logic [KIND_W-1:0] K_NUMBER     = 6'd20;
    localparam logic [KIND_W-1:0] K_IDENT      = 6'd21;
    localparam logic [KIND_W-1:0] K_KW0        = 6'd22;
    localparam logic [KIND_W-1:0] K_END        = 6'd38;

    // Keyword spellings, first character at index 0, zero padded
    localparam logic [7:0] KW_TEXT [0:KW_COUNT-1][0:KW_CHARS-1] = '{
        '{"a", "n", "d", 8'h00, 8'h00, 8'h00},
        '{"c", "l", "a", "s", "s", 8'h00},
        '{"e", "l", "s", "e", 8'h00, 8'h00},
        '{"f", "a", "l", "s", "e", 8'h00},
        '{"f", "o", "r", 8'h00, 8'h00, 8'h00},
        '{"f", "u", "n", 8'h00, 8'h00, 8'h00},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"n", "i", "l", 8'h00, 8'h00, 8'h00},
        '{"o", "r", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"p", "r", "i", "n", "t", 8'h00},
        '{"r", "e", "t", "u", "r", "n"},
        '{"s", "u", "p", "e", "r", 8'h00},
        '{"t", "h", "i", "s", 8'h00, 8'h00},
        '{"t", "r", "u", "e", 8'h00, 8'h00},
        '{"v", "a", "r", 8'h00, 8'h00, 8'h00},
        '{"w", "h", "i", "l", "e", 8'h00}
    };
    localparam int KW_LEN [0:KW_COUNT-1] = '{3, 5, 4, 5, 3, 3, 2, 3, 2, 5, 6, 5, 4, 4, 3, 5};

    // One token word
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [FIELD_W-1:0] start;
        logic [FIELD_W-1:0] length;
        logic [LINE_W-1:0]  line;
    } tok_t;

    // Token candidate inside the front end
    typedef struct packed {
        logic vld;
        tok_t tok;
    } cand_t;

    // All tokens caused by one source byte, in order
    typedef struct packed {
        logic [1:0]                  cnt;
        tok_t [MAX_TOKENS-1:0]       tok;
    } grp_t;

endpackage

FILE: sv/lsl_front.sv
module lsl_front
    import lsl_pkg::*;
#(
    parameter int MAX_KEYWORD_LEN = MAX_KEYWORD_LEN_DEF,
    parameter int POSITION_BITS   = POSITION_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] char_in,
    input  logic       last_byte,
    output logic       push,
    output grp_t       grp
);

    localparam int P      = POSITION_BITS;
    localparam int ILEN_W = $clog2(MAX_KEYWORD_LEN + 2);
    localparam logic [P-1:0]      POS_MAX  = {P{1'b1}};
    localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};

    typedef logic [MAX_KEYWORD_LEN-1:0][7:0] kbuf_t;

    mode_t              mode_reg,   mode_next;
    logic [P-1:0]       pos_reg,    pos_next;
    logic [P-1:0]       lstart_reg, lstart_next;
    logic [LINE_W-1:0]  line_reg,   line_next;
    kbuf_t              kbuf_reg,   kbuf_next;
    logic [ILEN_W-1:0]  ilen_reg,   ilen_next;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
    endfunction

    function automatic logic [KIND_W-1:0] ident_kind(input kbuf_t kb,
                                                     input logic [ILEN_W-1:0] il);
        logic [KIND_W-1:0] k;
        logic              hit;
        k = K_IDENT;
        for (int i = 0; i < KW_COUNT; i++)
        begin
            hit = (il == ILEN_W'(KW_LEN[i]));
            for (int j = 0; j < KW_CHARS; j++)
            begin
                if ((j < KW_LEN[i]) && (kb[j] != KW_TEXT[i][j]))
                begin
                    hit = 1'b0;
                end
            end
            if (hit)
            begin
                k = K_KW0 + KIND_W'(i);
            end
        end
        return k;
    endfunction

    // Token that a pending mode yields when its lexeme ends before pos
    function automatic cand_t pend_tok(input mode_t m, input logic [P-1:0] ls,
                                       input logic [P-1:0] ps, input kbuf_t kb,
                                       input logic [ILEN_W-1:0] il,
                                       input logic [LINE_W-1:0] ln);
        cand_t r;
        r.vld        = 1'b1;
        r.tok.start  = FIELD_W'(ls);
        r.tok.length = FIELD_W'(1);
        r.tok.line   = ln;
        r.tok.kind   = K_SLASH;
        unique case (m)
            MODE_BANG:    r.tok.kind = K_BANG;
            MODE_EQ:      r.tok.kind = K_EQ;
            MODE_LESS:    r.tok.kind = K_LESS;
            MODE_GREATER: r.tok.kind = K_GREATER;
            MODE_SLASH:   r.tok.kind = K_SLASH;
            MODE_NUMBER:
            begin
                r.tok.kind   = K_NUMBER;
                r.tok.length = FIELD_W'(ps - ls);
            end
            MODE_IDENT:
            begin
                r.tok.kind   = ident_kind(kb, il);
                r.tok.length = FIELD_W'(ps - ls);
            end
            default:      r.vld = 1'b0;
        endcase
        return r;
    endfunction

    cand_t [3:0] cd;
    cand_t       flush_c;
    logic        dispatch;
    logic [1:0]  n;

    always_comb
    begin
        mode_next   = mode_reg;
        lstart_next = lstart_reg;
        line_next   = line_reg;
        kbuf_next   = kbuf_reg;
        ilen_next   = ilen_reg;
        dispatch    = 1'b0;
        cd          = '0;
        flush_c     = pend_tok(mode_reg, lstart_reg, pos_reg, kbuf_reg, ilen_reg, line_reg);

        // Slot 0: pending flush, two-character operator or string
        unique case (mode_reg)
            MODE_BANG, MODE_EQ, MODE_LESS, MODE_GREATER:
            begin
                if (char_in == "=")
                begin
                    cd[0].vld        = 1'b1;
                    cd[0].tok.kind   = flush_c.tok.kind + KIND_W'(1);
                    cd[0].tok.start  = FIELD_W'(lstart_reg);
                    cd[0].tok.length = FIELD_W'(2);
                    cd[0].tok.line   = line_reg;
                    mode_next        = MODE_IDLE;
                end
                else
                begin
                    cd[0]    = flush_c;
                    dispatch = 1'b1;
                end
            end
            MODE_SLASH:
            begin
                if (char_in == "/")
                begin
                    mode_next = MODE_COMMENT;
                end
                else
                begin
                    cd[0]    = flush_c;
                    dispatch = 1'b1;
                end
            end
            MODE_COMMENT:
            begin
                dispatch = (char_in == 8'h0A);
            end
            MODE_STRING:
            begin
                if (char_in == "\"")
                begin
                    cd[0].vld        = 1'b1;
                    cd[0].tok.kind   = K_STRING;
                    cd[0].tok.start  = (lstart_reg != POS_MAX) ?
                                       FIELD_W'(lstart_reg + P'(1)) : FIELD_W'(POS_MAX);
                    cd[0].tok.length = (pos_reg > lstart_reg) ?
                                       FIELD_W'(pos_reg - lstart_reg - P'(1)) : '0;
                    cd[0].tok.line   = line_reg;
                    mode_next        = MODE_IDLE;
                end
                else if ((char_in == 8'h0A) && (line_reg != LINE_MAX))
                begin
                    line_next = line_reg + LINE_W'(1);
                end
            end
            MODE_NUMBER:
            begin
                if (!is_digit(char_in))
                begin
                    cd[0]    = flush_c;
                    dispatch = 1'b1;
                end
            end
            MODE_IDENT:
            begin
                if (is_alpha(char_in) || is_digit(char_in))
                begin
                    if (ilen_reg < ILEN_W'(MAX_KEYWORD_LEN))
                    begin
                        kbuf_next[ilen_reg[$clog2(MAX_KEYWORD_LEN)-1:0]] = char_in;
                        ilen_next = ilen_reg + ILEN_W'(1);
                    end
                    else
                    begin
                        ilen_next = ILEN_W'(MAX_KEYWORD_LEN + 1);
                    end
                end
                else
                begin
                    cd[0]    = flush_c;
                    dispatch = 1'b1;
                end
            end
            default:
            begin
                dispatch = 1'b1;
            end
        endcase

        // Slot 1: single-character punctuation; else start a new lexeme
        if (dispatch)
        begin
            lstart_next      = pos_reg;
            mode_next        = MODE_IDLE;
            cd[1].vld        = 1'b1;
            cd[1].tok.start  = FIELD_W'(pos_reg);
            cd[1].tok.length = FIELD_W'(1);
            cd[1].tok.line   = line_reg;
            cd[1].tok.kind   = K_LPAREN;
            unique case (char_in)
                "(":  cd[1].tok.kind = K_LPAREN;
                ")":  cd[1].tok.kind = K_RPAREN;
                "{":  cd[1].tok.kind = K_LBRACE;
                "}":  cd[1].tok.kind = K_RBRACE;
                ",":  cd[1].tok.kind = K_COMMA;
                ".":  cd[1].tok.kind = K_DOT;
                "-":  cd[1].tok.kind = K_MINUS;
                "+":  cd[1].tok.kind = K_PLUS;
                ";":  cd[1].tok.kind = K_SEMI;
                "*":  cd[1].tok.kind = K_STAR;
                default:
                begin
                    cd[1].vld = 1'b0;
                    if (char_in == "!")       mode_next = MODE_BANG;
                    else if (char_in == "=")  mode_next = MODE_EQ;
                    else if (char_in == "<")  mode_next = MODE_LESS;
                    else if (char_in == ">")  mode_next = MODE_GREATER;
                    else if (char_in == "/")  mode_next = MODE_SLASH;
                    else if (char_in == "\"") mode_next = MODE_STRING;
                    else if (is_digit(char_in)) mode_next = MODE_NUMBER;
                    else if (is_alpha(char_in))
                    begin
                        mode_next    = MODE_IDENT;
                        kbuf_next[0] = char_in;
                        ilen_next    = ILEN_W'(1);
                    end
                    else if ((char_in == 8'h0A) && (line_reg != LINE_MAX))
                    begin
                        line_next = line_reg + LINE_W'(1);
                    end
                end
            endcase
        end

        pos_next = (pos_reg != POS_MAX) ? pos_reg + P'(1) : pos_reg;

        // Slots 2 and 3: final flush and end token, then back to reset state
        if (last_byte)
        begin
            if ((mode_next != MODE_STRING) && (mode_next != MODE_COMMENT))
            begin
                cd[2] = pend_tok(mode_next, lstart_next, pos_next, kbuf_next, ilen_next,
                                 line_next);
            end
            cd[3].vld        = 1'b1;
            cd[3].tok.kind   = K_END;
            cd[3].tok.start  = FIELD_W'(pos_next);
            cd[3].tok.length = '0;
            cd[3].tok.line   = line_next;
            mode_next        = MODE_IDLE;
            pos_next         = '0;
            lstart_next      = '0;
            line_next        = LINE_W'(1);
            ilen_next        = '0;
        end

        // Pack the valid slots in order
        grp = '0;
        n   = 2'd0;
        for (int i = 0; i < 4; i++)
        begin
            if (cd[i].vld && (n != 2'(MAX_TOKENS)))
            begin
                grp.tok[n] = cd[i].tok;
                n          = n + 2'd1;
            end
        end
        grp.cnt = n;
        push    = accept && (n != 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            pos_reg    <= '0;
            lstart_reg <= '0;
            line_reg   <= LINE_W'(1);
            ilen_reg   <= '0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            lstart_reg <= lstart_next;
            line_reg   <= line_next;
            ilen_reg   <= ilen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kbuf_reg <= kbuf_next;
        end
    end

endmodule

FILE: sv/lsl_queue.sv
module lsl_queue
    import lsl_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  grp_t wdata,
    input  logic pop,
    output grp_t rdata,
    output logic full,
    output logic empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    grp_t           slot_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg,  count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    assign rdata = slot_reg[rd_ptr_reg];
    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
        else $error("push into full token queue");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) empty |-> !pop)
        else $error("pop from empty token queue");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
                                    count_reg <= CW'(DEPTH))
        else $error("token queue count out of range");

endmodule

FILE: sv/lsl_back.sv
module lsl_back
    import lsl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  grp_t               head,
    input  logic               empty,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [KIND_W-1:0]  token_kind,
    output logic [FIELD_W-1:0] token_start,
    output logic [FIELD_W-1:0] token_length,
    output logic [LINE_W-1:0]  token_line,
    output logic               last_of_run
);

    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    tok_t       tok_reg;
    logic       last_reg;
    logic       load;
    logic       last;

    always_comb
    begin
        last           = (idx_reg == (head.cnt - 2'd1));
        load           = !empty && (!out_valid_reg || !out_stall);
        pop            = load && last;
        idx_next       = idx_reg;
        if (load)
        begin
            idx_next = last ? 2'd0 : idx_reg + 2'd1;
        end
        out_valid_next = load || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tok_reg  <= head.tok[idx_reg];
            last_reg <= last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign token_kind   = tok_reg.kind;
    assign token_start  = tok_reg.start;
    assign token_length = tok_reg.length;
    assign token_line   = tok_reg.line;
    assign last_of_run  = last_reg;

endmodule

FILE: sv/lox_style_lexer.sv
// Streaming lexer: one source byte in, zero to three token words out.
//
// Input channel: in_valid / in_stall carry char_in and last_byte. A byte is
// taken at a rising edge with in_valid high and in_stall low. Set last_byte
// on the final byte of a text; the block then flushes any pending token,
// emits an end token and starts the next text at offset 0, line 1.
// Output channel: out_valid / out_stall carry one token word per handshake
// (kind, start, length, line, last_of_run). last_of_run marks the final
// word caused by one input byte.
// Throughput: one byte per cycle while the queue has room. The front end
// classifies each byte in the cycle it is taken and pushes its words as one
// group into a four-group queue; the back end drains one word per cycle
// into the output register while out_stall is low. A word passes through
// the group queue and then the output register before it is on the output.
// Stall: out_stall holds the output register; once the queue fills, in_stall
// rises until the back end frees a group.
// Reset (rst_n, asynchronous, active low): queue and output empty, scanner
// idle at offset 0, line 1.
module lox_style_lexer
    import lsl_pkg::*;
#(
    parameter int MAX_KEYWORD_LEN = MAX_KEYWORD_LEN_DEF,
    parameter int POSITION_BITS   = POSITION_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         char_in,
    input  logic               last_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [KIND_W-1:0]  token_kind,
    output logic [FIELD_W-1:0] token_start,
    output logic [FIELD_W-1:0] token_length,
    output logic [LINE_W-1:0]  token_line,
    output logic               last_of_run
);

    logic accept;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;
    grp_t push_grp;
    grp_t head_grp;

    // Hold input while the queue has no free group
    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    lsl_front #(
        .MAX_KEYWORD_LEN (MAX_KEYWORD_LEN),
        .POSITION_BITS   (POSITION_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .char_in   (char_in),
        .last_byte (last_byte),
        .push      (push),
        .grp       (push_grp)
    );

    lsl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (push_grp),
        .pop   (pop),
        .rdata (head_grp),
        .full  (q_full),
        .empty (q_empty)
    );

    lsl_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head_grp),
        .empty        (q_empty),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .token_kind   (token_kind),
        .token_start  (token_start),
        .token_length (token_length),
        .token_line   (token_line),
        .last_of_run  (last_of_run)
    );

    // An end token always closes its run
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
                                    (out_valid && (token_kind == K_END)) |-> last_of_run)
        else $error("end token not marked last of run");
    // A token kind never exceeds the end code
    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
                                   out_valid |-> (token_kind <= K_END))
        else $error("token kind out of range");

endmodule

FILE: tb/sv/lox_style_lexer_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the streaming lexer.
// Source bytes go in one word per handshake; token words come back out and are
// checked field by field, in order, against typed-in words or a scanner model kept here.
module lox_style_lexer_tb;
    import lsl_pkg::*;

    // One expected or observed token word
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [FIELD_W-1:0] start;
        logic [FIELD_W-1:0] length;
        logic [LINE_W-1:0]  line;
        logic               lor;
    } word_t;

    // One stimulus row: a source byte and, where it is obvious, its words typed in.
    // A count of PRED leaves the words to the scanner model.
    typedef struct {
        logic [7:0] ch;
        logic       fin;
        int         fixed_n;
        word_t      w0;
        word_t      w1;
    } row_t;

    localparam int         PRED    = -1;
    localparam word_t      NO_WORD = '0;
    localparam logic [7:0] LF      = 8'h0A;
    localparam logic [7:0] QUOTE   = 8'h22;

    localparam string PUNCT     = "(){},.-+;*";
    localparam string OPS       = "!=<>/";
    localparam string DIGITS    = "0123456789";
    localparam string ALPHA     = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    localparam string ALNUM     = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    localparam string BLANKS    = " \t\015\n";
    localparam string STR_BODY  = "ab z9(+\n";
    localparam string NOTE_BODY = "ab =(*\t";

    // Keyword spellings, in token kind order starting at K_KW0
    string kw_spell [16] = '{"and", "class", "else", "false", "for", "fun", "if", "nil",
                             "or", "print", "return", "super", "this", "true", "var",
                             "while"};

    // Idle and stall percentages per random phase: none, sender, receiver, both
    localparam int IDLE_PLAN  [4] = '{0, 85, 0, 33};
    localparam int STALL_PLAN [4] = '{0, 0, 85, 33};
    localparam int PHASE_BYTES    = 85;
    localparam int HOLD_CYCLES    = 300;

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    logic [7:0]         char_in   = 8'h00;
    logic               last_byte = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [KIND_W-1:0]  token_kind;
    logic [FIELD_W-1:0] token_start;
    logic [FIELD_W-1:0] token_length;
    logic [LINE_W-1:0]  token_line;
    logic               last_of_run;

    lox_style_lexer u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .char_in      (char_in),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .token_kind   (token_kind),
        .token_start  (token_start),
        .token_length (token_length),
        .token_line   (token_line),
        .last_of_run  (last_of_run)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // ------------------------------------------------------------------
    // Scanner model: its own copy of mode, offsets, line and identifier buffer
    // ------------------------------------------------------------------
    mode_t       scan_st;
    logic [31:0] at_pos;
    logic [31:0] lex_pos;
    logic [31:0] line_no;
    logic [7:0]  id_buf [0:MAX_KEYWORD_LEN_DEF-1];
    int          id_len;
    word_t       step_words [MAX_TOKENS];
    int          step_n;

    function automatic void reset_scanner();
        scan_st = MODE_IDLE;
        at_pos  = '0;
        lex_pos = '0;
        line_no = 32'd1;
        id_len  = 0;
        foreach (id_buf[i])
            id_buf[i] = 8'h00;
    endfunction

    function automatic logic [31:0] sat_inc(logic [31:0] v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic void add_word(logic [KIND_W-1:0] k, logic [31:0] s, logic [31:0] l);
        if (step_n < MAX_TOKENS)
        begin
            step_words[step_n] = '{k, s, l, line_no, 1'b0};
            step_n++;
        end
    endfunction

    // Distance of a comparison operator from '!' in the kind numbering
    function automatic logic [KIND_W-1:0] op_off();
        return KIND_W'(2 * (int'(scan_st) - int'(MODE_BANG)));
    endfunction

    // Keyword lookup; anything longer than the buffer is a plain identifier
    function automatic logic [KIND_W-1:0] ident_kind();
        bit same;
        if (id_len > MAX_KEYWORD_LEN_DEF)
            return K_IDENT;
        for (int i = 0; i < 16; i++)
        begin
            if (kw_spell[i].len() == id_len)
            begin
                same = 1'b1;
                for (int j = 0; j < id_len; j++)
                    if (id_buf[j] != kw_spell[i][j])
                        same = 1'b0;
                if (same)
                    return K_KW0 + KIND_W'(i);
            end
        end
        return K_IDENT;
    endfunction

    // Emit whatever token is pending, ending just before the current byte
    function automatic void flush_pending();
        case (scan_st)
            MODE_BANG, MODE_EQ, MODE_LESS, MODE_GREATER:
                add_word(K_BANG + op_off(), lex_pos, 32'd1);
            MODE_SLASH:
                add_word(K_SLASH, lex_pos, 32'd1);
            MODE_NUMBER:
                add_word(K_NUMBER, lex_pos, at_pos - lex_pos);
            MODE_IDENT:
                add_word(ident_kind(), lex_pos, at_pos - lex_pos);
            default:
                ;
        endcase
        scan_st = MODE_IDLE;
    endfunction

    // Start a new lexeme on byte c from the idle mode
    function automatic void start_lexeme(logic [7:0] c);
        lex_pos = at_pos;
        for (int i = 0; i < 10; i++)
        begin
            if (PUNCT[i] == c)
            begin
                add_word(K_LPAREN + KIND_W'(i), at_pos, 32'd1);
                return;
            end
        end
        if (c == "!")
            scan_st = MODE_BANG;
        else if (c == "=")
            scan_st = MODE_EQ;
        else if (c == "<")
            scan_st = MODE_LESS;
        else if (c == ">")
            scan_st = MODE_GREATER;
        else if (c == "/")
            scan_st = MODE_SLASH;
        else if (c == QUOTE)
            scan_st = MODE_STRING;
        else if (is_digit(c))
            scan_st = MODE_NUMBER;
        else if (is_alpha(c))
        begin
            scan_st   = MODE_IDENT;
            id_buf[0] = c;
            id_len    = 1;
        end
        else if (c == LF)
            line_no = sat_inc(line_no);
        // blanks and stray bytes fall through with no effect
    endfunction

    function automatic void scan_char(logic [7:0] c);
        case (scan_st)
            MODE_BANG, MODE_EQ, MODE_LESS, MODE_GREATER:
            begin
                if (c == "=")
                begin
                    add_word(K_BANG_EQ + op_off(), lex_pos, 32'd2);
                    scan_st = MODE_IDLE;
                    return;
                end
                flush_pending();
            end
            MODE_SLASH:
            begin
                if (c == "/")
                begin
                    scan_st = MODE_COMMENT;
                    return;
                end
                flush_pending();
            end
            MODE_COMMENT:
            begin
                if (c != LF)
                    return;
                scan_st = MODE_IDLE;
            end
            MODE_STRING:
            begin
                if (c == QUOTE)
                begin
                    add_word(K_STRING, sat_inc(lex_pos),
                             (at_pos > lex_pos) ? at_pos - lex_pos - 32'd1 : 32'd0);
                    scan_st = MODE_IDLE;
                end
                else if (c == LF)
                    line_no = sat_inc(line_no);
                return;
            end
            MODE_NUMBER:
            begin
                if (is_digit(c))
                    return;
                flush_pending();
            end
            MODE_IDENT:
            begin
                if (is_alpha(c) || is_digit(c))
                begin
                    if (id_len < MAX_KEYWORD_LEN_DEF)
                    begin
                        id_buf[id_len] = c;
                        id_len++;
                    end
                    else
                        id_len = MAX_KEYWORD_LEN_DEF + 1;
                    return;
                end
                flush_pending();
            end
            default:
                scan_st = MODE_IDLE;
        endcase
        start_lexeme(c);
    endfunction

    // Advance the model by one source byte; the words land in step_words
    function automatic int scan_byte(logic [7:0] c, logic fin);
        step_n = 0;
        scan_char(c);
        at_pos = sat_inc(at_pos);
        if (fin)
        begin
            if (scan_st != MODE_STRING && scan_st != MODE_COMMENT)
                flush_pending();
            scan_st = MODE_IDLE;
            add_word(K_END, at_pos, 32'd0);
            reset_scanner();
        end
        if (step_n > 0)
            step_words[step_n - 1].lor = 1'b1;
        return step_n;
    endfunction

    // ------------------------------------------------------------------
    // Directed rows. Words are typed in only where they are plain to see:
    // right after reset, stray bytes at both ends of the byte range, a
    // two-character operator, a newline and a lone slash closing a text.
    // ------------------------------------------------------------------
    row_t plan [26] = '{
        '{"(",   1'b0, 1,    '{K_LPAREN, 32'd0, 32'd1, 32'd1, 1'b1}, NO_WORD},
        '{8'hFF, 1'b0, 0,    NO_WORD, NO_WORD},
        '{8'h00, 1'b0, 0,    NO_WORD, NO_WORD},
        '{"!",   1'b0, 0,    NO_WORD, NO_WORD},
        '{"=",   1'b0, 1,    '{K_BANG_EQ, 32'd3, 32'd2, 32'd1, 1'b1}, NO_WORD},
        '{LF,    1'b0, 0,    NO_WORD, NO_WORD},
        '{QUOTE, 1'b0, PRED, NO_WORD, NO_WORD},
        '{"a",   1'b0, PRED, NO_WORD, NO_WORD},
        '{LF,    1'b0, PRED, NO_WORD, NO_WORD},
        '{QUOTE, 1'b0, PRED, NO_WORD, NO_WORD},
        '{"w",   1'b0, PRED, NO_WORD, NO_WORD},
        '{"h",   1'b0, PRED, NO_WORD, NO_WORD},
        '{"i",   1'b0, PRED, NO_WORD, NO_WORD},
        '{"l",   1'b0, PRED, NO_WORD, NO_WORD},
        '{"e",   1'b0, PRED, NO_WORD, NO_WORD},
        '{" ",   1'b0, PRED, NO_WORD, NO_WORD},
        '{"/",   1'b0, PRED, NO_WORD, NO_WORD},
        '{"/",   1'b0, PRED, NO_WORD, NO_WORD},
        '{"x",   1'b0, PRED, NO_WORD, NO_WORD},
        '{LF,    1'b0, PRED, NO_WORD, NO_WORD},
        '{"9",   1'b0, PRED, NO_WORD, NO_WORD},
        '{"<",   1'b0, PRED, NO_WORD, NO_WORD},
        '{"=",   1'b0, PRED, NO_WORD, NO_WORD},
        '{">",   1'b0, PRED, NO_WORD, NO_WORD},
        // open string at the final byte: pending '>' flushes, then only the end word
        '{QUOTE, 1'b1, PRED, NO_WORD, NO_WORD},
        '{"/",   1'b1, 2,    '{K_SLASH, 32'd0, 32'd1, 32'd1, 1'b0},
                             '{K_END, 32'd1, 32'd0, 32'd1, 1'b1}}
    };

    localparam row_t NO_ROW = '{8'h00, 1'b0, PRED, NO_WORD, NO_WORD};

    row_t        row_q [$];     // rows offered to the block, oldest first
    word_t       token_q [$];   // token words still owed by the block
    logic [7:0]  text_q [$];    // bytes of the text being generated
    int          idle_pct    = 0;
    int          stall_pct   = 0;
    bit          hold_req    = 1'b0;
    int          errors      = 0;
    int          bytes_taken = 0;
    int          words_seen  = 0;
    int          texts       = 0;
    int          fill_stalls = 0;
    logic [63:0] kinds_seen  = '0;

    // ------------------------------------------------------------------
    // Random source text: mostly well-formed tokens, with stray bytes mixed in
    // ------------------------------------------------------------------
    function automatic logic [7:0] pick(string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    function automatic void put(logic [7:0] b);
        text_q.insert(text_q.size(), b);
    endfunction

    function automatic void put_str(string s);
        foreach (s[i])
            put(s[i]);
    endfunction

    // Build one text into text_q; return its length in bytes
    function automatic int make_text();
        int n_tok;
        int r;
        int len;
        text_q.delete();
        n_tok = $urandom_range(2, 24);
        repeat (n_tok)
        begin
            r = $urandom_range(0, 99);
            if (r < 12)
                put(pick(PUNCT));
            else if (r < 24)
            begin
                put(pick(OPS));
                if ($urandom_range(0, 1) == 1)
                    put("=");
            end
            else if (r < 40)
            begin
                // keyword, now and then stretched into a plain identifier
                put_str(kw_spell[$urandom_range(0, 15)]);
                if ($urandom_range(0, 4) == 0)
                    put(pick(ALNUM));
            end
            else if (r < 55)
            begin
                put(pick(ALPHA));
                len = $urandom_range(0, 9);
                repeat (len)
                    put(pick(ALNUM));
            end
            else if (r < 65)
            begin
                len = $urandom_range(1, 5);
                repeat (len)
                    put(pick(DIGITS));
            end
            else if (r < 75)
            begin
                put(QUOTE);
                len = $urandom_range(0, 6);
                repeat (len)
                    put(pick(STR_BODY));
                put(QUOTE);
            end
            else if (r < 82)
            begin
                put_str("//");
                len = $urandom_range(0, 5);
                repeat (len)
                    put(pick(NOTE_BODY));
                put(LF);
            end
            else if (r < 92)
                put(8'($urandom_range(0, 255)));
            else
                put(LF);
            if ($urandom_range(0, 99) < 60)
                put(pick(BLANKS));
        end
        // now and then leave a string or a comment open at the end
        r = $urandom_range(0, 9);
        if (r == 0)
            put_str("\"ab");
        else if (r == 1)
            put_str("//x");
        return text_q.size();
    endfunction

    // ------------------------------------------------------------------
    // Sender: idle at random, then hold the word until the block takes it
    // ------------------------------------------------------------------
    task automatic offer(input logic [7:0] c, input logic fin, input row_t r);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        row_q.insert(row_q.size(), r);
        in_valid  <= 1'b1;
        char_in   <= c;
        last_byte <= fin;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // ------------------------------------------------------------------
    // Receiver: stall at random; on request hold off for a long stretch so the
    // group queue fills and the block stalls its input.
    // ------------------------------------------------------------------
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
            end
            else
                out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    function automatic int field_diff(string name, logic [31:0] want, logic [31:0] seen);
        if (want !== seen)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, seen);
            return 1;
        end
        return 0;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: both handshakes are sampled at the rising edge. A taken byte
    // advances the model and queues its words; a taken output word is compared
    // with the oldest one queued.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        row_t  r;
        int    n;
        word_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                r = row_q.pop_front();
                n = scan_byte(char_in, last_byte);
                bytes_taken++;
                if (r.fixed_n == PRED)
                begin
                    for (int i = 0; i < n; i++)
                        token_q.insert(token_q.size(), step_words[i]);
                end
                else
                begin
                    if (r.fixed_n > 0)
                        token_q.insert(token_q.size(), r.w0);
                    if (r.fixed_n > 1)
                        token_q.insert(token_q.size(), r.w1);
                end
            end
            if (in_valid && in_stall)
                fill_stalls++;
            if (out_valid && !out_stall)
            begin
                words_seen++;
                kinds_seen[token_kind] = 1'b1;
                if (token_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected token word, kind %0d start %0d length %0d",
                             $time, token_kind, token_start, token_length);
                end
                else
                begin
                    want = token_q.pop_front();
                    errors += field_diff("token_kind", want.kind, token_kind)
                            + field_diff("token_start", want.start, token_start)
                            + field_diff("token_length", want.length, token_length)
                            + field_diff("token_line", want.line, token_line)
                            + field_diff("last_of_run", want.lor, last_of_run);
                end
            end
        end
    end

    // Hard stop in case the block hangs
    initial
    begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int kept;
        int guard;
        reset_scanner();
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows, back to back
        foreach (plan[i])
            offer(plan[i].ch, plan[i].fin, plan[i]);

        // random texts over the idling phases; the first phase opens with
        // the long output hold while bytes keep coming
        for (int p = 0; p < 4; p++)
        begin
            idle_pct  = IDLE_PLAN[p];
            stall_pct = STALL_PLAN[p];
            if (p == 0)
                hold_req = 1'b1;
            kept = 0;
            while (kept < PHASE_BYTES)
            begin
                kept += make_text();
                texts++;
                foreach (text_q[i])
                    offer(text_q[i], i == text_q.size() - 1, NO_ROW);
            end
        end
        in_valid <= 1'b0;

        // drain what is still owed, then allow the output latency to pass
        guard = 0;
        while (token_q.size() != 0 && guard < 100_000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (20)
            @(posedge clk);

        if (token_q.size() != 0)
        begin
            errors++;
            $display("%0t: %0d token words never arrived", $time, token_q.size());
        end
        $display("Run: %0d directed bytes and %0d random texts, %0d bytes taken, %0d words checked",
                 $size(plan), texts, bytes_taken, words_seen);
        $display("Token kinds seen: %0d of 39; input held off by back-pressure on %0d cycles",
                 $countones(kinds_seen), fill_stalls);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: lox_style_lexer.f
sv/lsl_pkg.sv
sv/lsl_front.sv
sv/lsl_queue.sv
sv/lsl_back.sv
sv/lox_style_lexer.sv
tb/sv/lox_style_lexer_tb.sv
